// ===== src/fpmac_pkg.sv =====
// Shared types and constants for the fixed-point multiply-accumulate core.
// Holds operation and compare codes plus the stage payload structs.
// No dependencies.
package fpmac_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MAC  = 2'd1;
  localparam logic [1:0] OP_CEIL = 2'd2;
  localparam logic [1:0] OP_CMP  = 2'd3;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam logic [31:0] MUL_MIN    = 32'h8000_0000;
  localparam logic [63:0] OPND_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [31:0] INT_HI_MAX = 32'h7fff_ffff;
  localparam logic [33:0] SPLIT_BIAS = 34'd32768;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] mul;
    logic [63:0] operand;
    logic        pre_ovf;
    logic [31:0] y_lo;
    logic [30:0] y_hi;
    logic [15:0] mlo;
    logic [15:0] mhi;
  } prep_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] mul;
    logic [63:0] operand;
    logic        pre_ovf;
    logic [48:0] pll;
    logic [47:0] phl;
    logic [48:0] plh;
    logic [47:0] phh;
  } prod_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] mul;
    logic [63:0] operand;
    logic        pre_ovf;
    logic [79:0] p1;
    logic [95:0] pfull;
  } sum_t;

endpackage

// ===== src/fixed_point_mac_accumulator_core.sv =====
// Top level of the signed 32.32 fixed-point multiply-accumulate core.
// Depends on fpmac_pkg, fpmac_prep, fpmac_mult, fpmac_sum and fpmac_acc.
//
// Usage:
//   Input items arrive on the s_axis group: tuser carries the operation
//   (load, multiply-accumulate, ceiling, compare), tdata the operand and
//   the multiplier. Every item gives exactly one result item on the m_axis
//   group: the accumulator after the step, the compare code and an overflow
//   flag. On overflow the accumulator keeps its value.
//   The accepting edge captures the operand fold and multiplier split, then
//   partial products, product sum and accumulate into the output register
//   are each registered in turn before m_axis_tvalid rises. The accumulator
//   is only read in the last stage, so one item per cycle is accepted back
//   to back while the receiver keeps m_axis_tready high.
//   Reset clears the accumulator and all stage valids.
//   When the receiver stalls, the output holds and the stages behind it fill
//   up; s_axis_tready drops once every stage holds an item.
module fixed_point_mac_accumulator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // operand [63:0], multiplier [95:64]
  input  logic [1:0]  s_axis_tuser,  // op [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // acc_value [63:0], cmp_result [65:64],
                                     // overflow [66], zero [71:67]
);

  logic v1;
  logic v2;
  logic v3;
  logic en0;
  logic en1;
  logic en2;
  logic en3;
  fpmac_pkg::prep_t prep_q;
  fpmac_pkg::prod_t prod_q;
  fpmac_pkg::sum_t  sum_q;
  logic [63:0] acc_value;
  logic [1:0]  cmp_result;
  logic        overflow;

  assign en3 = !m_axis_tvalid || m_axis_tready;
  assign en2 = !v3 || en3;
  assign en1 = !v2 || en2;
  assign en0 = !v1 || en1;
  assign s_axis_tready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) begin
        v1 <= s_axis_tvalid;
      end
      if (en1) begin
        v2 <= v1;
      end
      if (en2) begin
        v3 <= v2;
      end
    end
  end

  fpmac_prep u_prep (
    .clk        (clk),
    .en         (en0),
    .op         (s_axis_tuser),
    .operand    (s_axis_tdata[63:0]),
    .multiplier (s_axis_tdata[95:64]),
    .q          (prep_q)
  );

  fpmac_mult u_mult (
    .clk (clk),
    .en  (en1),
    .d   (prep_q),
    .q   (prod_q)
  );

  fpmac_sum u_sum (
    .clk (clk),
    .en  (en2),
    .d   (prod_q),
    .q   (sum_q)
  );

  fpmac_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .en         (en3),
    .vin        (v3),
    .d          (sum_q),
    .out_valid  (m_axis_tvalid),
    .acc_value  (acc_value),
    .cmp_result (cmp_result),
    .overflow   (overflow)
  );

  assign m_axis_tdata = {5'd0, overflow, cmp_result, acc_value};

endmodule

// ===== src/fpmac_prep.sv =====
// Input stage: sign fold of the operand and signed 16-bit split of the multiplier.
// Registers the result as a prep_t; depends on fpmac_pkg.
module fpmac_prep (
  input  logic               clk,
  input  logic               en,
  input  logic [1:0]         op,
  input  logic [63:0]        operand,
  input  logic [31:0]        multiplier,
  output fpmac_pkg::prep_t   q
);

  logic        neg;
  logic [32:0] m_ext;
  logic [32:0] m_fold;
  logic [63:0] y;
  logic [33:0] t;
  logic [17:0] mhi_wide;
  logic        hi_ovf;
  fpmac_pkg::prep_t q_next;

  assign neg      = operand[63];
  assign m_ext    = {multiplier[31], multiplier};
  assign m_fold   = neg ? (33'd0 - m_ext) : m_ext;
  assign y        = neg ? (64'd0 - operand) : operand;
  assign t        = {m_fold[32], m_fold} + fpmac_pkg::SPLIT_BIAS;
  assign mhi_wide = t[33:16];
  assign hi_ovf   = !((mhi_wide[17:15] == 3'b000) || (mhi_wide[17:15] == 3'b111));

  always_comb begin
    q_next.op      = op;
    q_next.mul     = multiplier;
    q_next.operand = operand;
    q_next.pre_ovf = (multiplier == fpmac_pkg::MUL_MIN) ||
                     (operand == fpmac_pkg::OPND_MIN) || hi_ovf;
    q_next.y_lo    = y[31:0];
    q_next.y_hi    = y[62:32];
    q_next.mlo     = {~t[15], t[14:0]};
    q_next.mhi     = mhi_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== src/fpmac_mult.sv =====
// Multiply stage: four signed partial products of y_lo (32 bits) and y_hi (31 bits) against mlo and mhi.
// Registers the result as a prod_t; depends on fpmac_pkg.
module fpmac_mult (
  input  logic               clk,
  input  logic               en,
  input  fpmac_pkg::prep_t   d,
  output fpmac_pkg::prod_t   q
);

  logic signed [48:0] pll;
  logic signed [47:0] phl;
  logic signed [48:0] plh;
  logic signed [47:0] phh;

  assign pll = $signed({1'b0, d.y_lo}) * $signed(d.mlo);
  assign phl = $signed({1'b0, d.y_hi}) * $signed(d.mlo);
  assign plh = $signed({1'b0, d.y_lo}) * $signed(d.mhi);
  assign phh = $signed({1'b0, d.y_hi}) * $signed(d.mhi);

  always_ff @(posedge clk) begin
    if (en) begin
      q.op      <= d.op;
      q.mul     <= d.mul;
      q.operand <= d.operand;
      q.pre_ovf <= d.pre_ovf;
      q.pll     <= pll;
      q.phl     <= phl;
      q.plh     <= plh;
      q.phh     <= phh;
    end
  end

endmodule

// ===== src/fpmac_sum.sv =====
// Product sum stage: forms y*mlo and the full y*m from the partial products.
// Registers the result as a sum_t; depends on fpmac_pkg.
module fpmac_sum (
  input  logic               clk,
  input  logic               en,
  input  fpmac_pkg::prod_t   d,
  output fpmac_pkg::sum_t    q
);

  logic [79:0] p1;
  logic [95:0] pfull;

  assign p1    = {{31{d.pll[48]}}, d.pll} + {d.phl, 32'd0};
  assign pfull = {{16{p1[79]}}, p1} + {{31{d.plh[48]}}, d.plh, 16'd0} + {d.phh, 48'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      q.op      <= d.op;
      q.mul     <= d.mul;
      q.operand <= d.operand;
      q.pre_ovf <= d.pre_ovf;
      q.p1      <= p1;
      q.pfull   <= pfull;
    end
  end

endmodule

// ===== src/fpmac_acc.sv =====
// Accumulator stage: applies load, multiply-accumulate, ceiling or compare,
// holds the accumulator and the output register; depends on fpmac_pkg.
module fpmac_acc (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  fpmac_pkg::sum_t    d,
  output logic               out_valid,
  output logic [63:0]        acc_value,
  output logic [1:0]         cmp_result,
  output logic               overflow
);

  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [1:0]  cmp_next;
  logic        ovf_next;
  logic [80:0] s1;
  logic [95:0] s2;
  logic        fits1;
  logic        fits2;

  assign s1    = {{17{acc[63]}}, acc} + {d.p1[79], d.p1};
  assign s2    = {{32{acc[63]}}, acc} + d.pfull;
  assign fits1 = (&s1[80:63]) || !(|s1[80:63]);
  assign fits2 = (&s2[95:63]) || !(|s2[95:63]);

  always_comb begin
    acc_next = acc;
    cmp_next = fpmac_pkg::CMP_EQ;
    ovf_next = 1'b0;
    case (d.op)
      fpmac_pkg::OP_LOAD: begin
        if (d.mul == fpmac_pkg::MUL_MIN) begin
          ovf_next = 1'b1;
        end else begin
          acc_next = {d.mul, 32'd0};
        end
      end
      fpmac_pkg::OP_MAC: begin
        if (d.pre_ovf || !fits1 || !fits2) begin
          ovf_next = 1'b1;
        end else begin
          acc_next = s2[63:0];
        end
      end
      fpmac_pkg::OP_CEIL: begin
        if (|acc[31:0]) begin
          if (acc[63:32] == fpmac_pkg::INT_HI_MAX) begin
            ovf_next = 1'b1;
          end else begin
            acc_next = {acc[63:32] + 32'd1, 32'd0};
          end
        end
      end
      fpmac_pkg::OP_CMP: begin
        if ($signed(acc) < $signed(d.operand)) begin
          cmp_next = fpmac_pkg::CMP_LT;
        end else if (acc == d.operand) begin
          cmp_next = fpmac_pkg::CMP_EQ;
        end else begin
          cmp_next = fpmac_pkg::CMP_GT;
        end
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 64'd0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vin;
      if (vin) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vin) begin
      acc_value  <= acc_next;
      cmp_result <= cmp_next;
      overflow   <= ovf_next;
    end
  end

  a_out_matches_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> acc_value == acc)
    else $error("output value differs from accumulator");

  a_ovf_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    en && vin && ovf_next |=> acc == $past(acc))
    else $error("accumulator changed on overflow");

  a_cmp_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmp_result != fpmac_pkg::CMP_EQ |-> !overflow)
    else $error("compare result with overflow");

  a_cmp_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cmp_result == fpmac_pkg::CMP_LT || cmp_result == fpmac_pkg::CMP_EQ ||
                   cmp_result == fpmac_pkg::CMP_GT))
    else $error("bad compare code");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> acc == 64'd0 && !out_valid)
    else $error("reset did not clear accumulator");

endmodule

// ===== test/fpmac_stream_checker.sv =====
`timescale 1ns / 100ps
// Checker for the fixed-point multiply-accumulate core: watches both stream groups,
// predicts each result item from the accepted input items and compares field by field.
// Depends on fpmac_pkg for operation, compare and limit codes.
module fpmac_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  output int          fail_count,
  output int          outstanding
);

  localparam int HALF_SHIFT = 16;
  localparam int HALF_MAX   = 32767;
  localparam int HALF_MIN   = -32768;

  typedef struct packed {
    logic [63:0] acc_value;
    logic [1:0]  cmp_result;
    logic        overflow;
  } acc_result_t;

  acc_result_t pending_results[$];
  acc_result_t want;
  acc_result_t got;
  logic [63:0] acc_model;
  int          errors;

  function automatic bit fits64(input logic signed [127:0] v);
    fits64 = (v[127:63] == '0) || (v[127:63] == '1);
  endfunction

  function automatic acc_result_t mac_step(input logic [63:0] acc, input logic [1:0] op,
                                           input logic [63:0] operand,
                                           input logic [31:0] mul);
    acc_result_t r;
    logic signed [127:0] a, y, mv, mlo, mhi, s1, s2;
    r.acc_value  = acc;
    r.cmp_result = fpmac_pkg::CMP_EQ;
    r.overflow   = 1'b0;
    case (op)
      fpmac_pkg::OP_LOAD: begin
        if (mul == fpmac_pkg::MUL_MIN) r.overflow = 1'b1;
        else r.acc_value = {mul, 32'd0};
      end
      fpmac_pkg::OP_MAC: begin
        if (mul == fpmac_pkg::MUL_MIN || operand == fpmac_pkg::OPND_MIN) begin
          r.overflow = 1'b1;
        end else begin
          a  = {{64{acc[63]}}, acc};
          y  = {{64{operand[63]}}, operand};
          mv = {{96{mul[31]}}, mul};
          if (y < 0) begin
            y  = -y;
            mv = -mv;
          end
          mlo = {{112{mv[15]}}, mv[15:0]};
          mhi = (mv - mlo) >>> HALF_SHIFT;
          if (mhi < HALF_MIN || mhi > HALF_MAX) begin
            r.overflow = 1'b1;
          end else begin
            s1 = a + y * mlo;
            s2 = s1 + y * (mhi <<< HALF_SHIFT);
            if (!fits64(s1) || !fits64(s2)) r.overflow = 1'b1;
            else r.acc_value = s2[63:0];
          end
        end
      end
      fpmac_pkg::OP_CEIL: begin
        if (acc[31:0] != 32'd0) begin
          if (acc[63:32] == fpmac_pkg::INT_HI_MAX) r.overflow = 1'b1;
          else r.acc_value = {acc[63:32] + 32'd1, 32'd0};
        end
      end
      default: begin
        if ($signed(acc) < $signed(operand)) r.cmp_result = fpmac_pkg::CMP_LT;
        else if (acc == operand) r.cmp_result = fpmac_pkg::CMP_EQ;
        else r.cmp_result = fpmac_pkg::CMP_GT;
      end
    endcase
    mac_step = r;
  endfunction

  initial begin
    errors      = 0;
    outstanding = 0;
    acc_model   = '0;
  end

  assign fail_count = errors;

  always @(posedge clk) begin
    if (rst) begin
      acc_model = '0;
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.acc_value  = m_axis_tdata[63:0];
        got.cmp_result = m_axis_tdata[65:64];
        got.overflow   = m_axis_tdata[66];
        if (pending_results.size() == 0) begin
          $error("unexpected result item: acc_value %h cmp_result %0d overflow %0d",
                 got.acc_value, got.cmp_result, got.overflow);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.acc_value !== want.acc_value) begin
            $error("acc_value expected %h actual %h", want.acc_value, got.acc_value);
            errors++;
          end
          if (got.cmp_result !== want.cmp_result) begin
            $error("cmp_result expected %0d actual %0d", want.cmp_result, got.cmp_result);
            errors++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = mac_step(acc_model, s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64]);
        acc_model = want.acc_value;
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== test/fixed_point_mac_accumulator_core_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the fixed-point multiply-accumulate core.
// Depends on fpmac_pkg, the core itself and fpmac_stream_checker.
module fixed_point_mac_accumulator_core_tb;

  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = fpmac_pkg::OP_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  int          sent = 0;
  bit          calm = 1'b0;

  fixed_point_mac_accumulator_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fpmac_stream_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_gap();
    draw_gap = calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: rand_operand = r;
      1: rand_operand = {{44{r[19]}}, r[19:0]};
      2: rand_operand = {{16{r[47]}}, r[47:32], 32'd0};
      3: begin
        case ($urandom_range(0, 4))
          0: rand_operand = fpmac_pkg::OPND_MIN;
          1: rand_operand = ~fpmac_pkg::OPND_MIN;
          2: rand_operand = 64'd0;
          3: rand_operand = 64'd1;
          default: rand_operand = '1;
        endcase
      end
      4: rand_operand = {{24{r[39]}}, r[39:0]};
      default: rand_operand = {32'd0, r[31:0]};
    endcase
  endfunction

  function automatic logic [31:0] rand_mul();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 4))
      0: rand_mul = r;
      1: rand_mul = {{24{r[7]}}, r[7:0]};
      2: begin
        case ($urandom_range(0, 9))
          0: rand_mul = fpmac_pkg::MUL_MIN;
          1: rand_mul = fpmac_pkg::INT_HI_MAX;
          2: rand_mul = 32'h7fff_8000;
          3: rand_mul = 32'h7fff_7fff;
          4: rand_mul = 32'd0;
          5: rand_mul = 32'd1;
          6: rand_mul = '1;
          7: rand_mul = 32'd32767;
          8: rand_mul = 32'd32768;
          default: rand_mul = 32'hffff_8000;
        endcase
      end
      3: rand_mul = {{16{r[15]}}, r[15:0]};
      default: rand_mul = r[0] ? 32'd1 : '1;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [63:0] operand,
                           input logic [31:0] mul);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mul, operand};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] k;
    logic [1:0]  op;
    int          n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(fpmac_pkg::OP_LOAD, '0, 32'd0);
    send_item(fpmac_pkg::OP_CMP, 64'd0, 32'd0);
    send_item(fpmac_pkg::OP_CMP, ~fpmac_pkg::OPND_MIN, 32'd0);
    send_item(fpmac_pkg::OP_CMP, fpmac_pkg::OPND_MIN, 32'd0);
    send_item(fpmac_pkg::OP_LOAD, '0, fpmac_pkg::INT_HI_MAX);
    send_item(fpmac_pkg::OP_MAC, 64'h0000_0001_0000_0000, 32'd1);
    send_item(fpmac_pkg::OP_MAC, 64'd1, 32'd1);
    send_item(fpmac_pkg::OP_CEIL, '0, '0);
    send_item(fpmac_pkg::OP_MAC, '1, 32'd1);
    send_item(fpmac_pkg::OP_CEIL, '0, '0);
    send_item(fpmac_pkg::OP_LOAD, '1, fpmac_pkg::MUL_MIN);
    send_item(fpmac_pkg::OP_LOAD, '0, 32'h8000_0001);
    send_item(fpmac_pkg::OP_MAC, fpmac_pkg::OPND_MIN, 32'd1);
    send_item(fpmac_pkg::OP_MAC, 64'd1, fpmac_pkg::MUL_MIN);
    send_item(fpmac_pkg::OP_MAC, 64'd1, 32'h7fff_8000);
    send_item(fpmac_pkg::OP_MAC, 64'd1, 32'h7fff_7fff);
    send_item(fpmac_pkg::OP_LOAD, '0, 32'd0);
    send_item(fpmac_pkg::OP_MAC, ~fpmac_pkg::OPND_MIN, 32'h7fff_7fff);
    send_item(fpmac_pkg::OP_MAC, 64'h0000_0000_8000_0000, 32'hffff_fffd);
    send_item(fpmac_pkg::OP_CEIL, '0, '0);
    send_item(fpmac_pkg::OP_CMP, 64'hffff_ffff_0000_0000, '0);
    send_item(fpmac_pkg::OP_LOAD, '0, 32'd0);
    send_item(fpmac_pkg::OP_MAC, 64'h0000_0001_0000_0000, 32'h7fff_0000);
    send_item(fpmac_pkg::OP_MAC, 64'h0000_0001_0000_0000, 32'h7fff_0000);
    send_item(fpmac_pkg::OP_MAC, '1, fpmac_pkg::INT_HI_MAX);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      if ($urandom_range(0, 9) < 7) begin
        k = ($urandom_range(0, 1) == 0) ? rand_mul() : {{20{1'b0}}, 12'($urandom)};
        send_item(fpmac_pkg::OP_LOAD, rand_operand(), k);
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0, 1, 2: send_item(fpmac_pkg::OP_MAC, rand_operand(), rand_mul());
            3: send_item(fpmac_pkg::OP_CEIL, rand_operand(), rand_mul());
            4: send_item(fpmac_pkg::OP_CMP, {k, 32'd0}, rand_mul());
            default: send_item(fpmac_pkg::OP_CMP, rand_operand(), rand_mul());
          endcase
        end
      end else begin
        op = 2'($urandom);
        send_item(op, rand_operand(), rand_mul());
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
